### src/angular_rate_window_estimator_unit_macros.svh
// ----------------------------------------------------------------------------
// Angular rate window estimator assertion macros
// Shared concurrent assertion helpers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ANGULAR_RATE_WINDOW_ESTIMATOR_UNIT_MACROS_SVH
`define ANGULAR_RATE_WINDOW_ESTIMATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ARWE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ARWE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ARWE_ASSERT_IMP(lbl, ante, cons, msg)
`define ARWE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### src/arwe_pkg.sv
// ----------------------------------------------------------------------------
// Angular rate window estimator package
// Widths, fixed-point constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package arwe_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 8;

  localparam int unsigned WS_W     = 3;
  localparam int unsigned WS_RESET = 4;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned VOTE_W   = 16;

  // Q3.12 angle constants and Q2.13 rate constants.
  localparam int TWO_PI_Q      = 25736;
  localparam int STEP_UNWRAP_Q = 24986;
  localparam int BLADE_Q       = 5147;
  localparam int WIN_UNWRAP_Q  = 24576;
  localparam int RATE_LIMIT_Q  = 17203;
  localparam int RATE_CLAMP_Q  = 17121;
  localparam int MAX_JUMPS     = 8;

  localparam int unsigned SCALE_W = 21;
  localparam logic [SCALE_W-1:0] RATE_SCALE = 21'd2000000;

  localparam int unsigned NUM_W  = ANGLE_W + SCALE_W;
  localparam int unsigned QUO_W  = 15;
  localparam int unsigned DEN_W  = TIME_W + QUO_W;
  localparam int unsigned IT_W   = $clog2(QUO_W);

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic step_calc;
    logic shift_wr;
    logic diff_calc;
    logic mul;
    logic div_init;
    logic div_iter;
    logic finish;
    logic out_load;
  } arwe_cmd_t;

  typedef struct packed {
    logic full;
    logic k_last;
    logic div_last;
    logic out_free;
  } arwe_sts_t;

endpackage

`default_nettype wire

### src/arwe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arwe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/arwe_ctrl.sv
// ----------------------------------------------------------------------------
// Angular rate window estimator controller
// Sequences one request through history update and, with a full window, blade shift and division.
// ----------------------------------------------------------------------------
`default_nettype none

`include "angular_rate_window_estimator_unit_macros.svh"

module arwe_ctrl
  import arwe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  arwe_sts_t sts_i,
  output arwe_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_STEP_RD   = 4'd1;
  localparam logic [3:0] S_STEP_CALC = 4'd2;
  localparam logic [3:0] S_SHIFT_RD  = 4'd3;
  localparam logic [3:0] S_SHIFT_WR  = 4'd4;
  localparam logic [3:0] S_DIFF      = 4'd5;
  localparam logic [3:0] S_MUL       = 4'd6;
  localparam logic [3:0] S_DIV_INIT  = 4'd7;
  localparam logic [3:0] S_DIV       = 4'd8;
  localparam logic [3:0] S_FINISH    = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.full ? S_STEP_RD : S_OUT;
        end
      end
      S_STEP_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_STEP_CALC;
      end
      S_STEP_CALC: begin
        cmd_o.step_calc = 1'b1;
        state_d         = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = sts_i.k_last ? S_DIFF : S_SHIFT_RD;
      end
      S_DIFF: begin
        cmd_o.diff_calc = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_iter = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ARWE_ASSERT_NXT(a_accept_leaves_idle, cmd_o.accept, state_q != S_IDLE,
                   "Controller stayed idle after accepting a request.")
  `ARWE_ASSERT_IMP(a_shift_after_read, state_q == S_SHIFT_WR,
                   $past(state_q) == S_SHIFT_RD,
                   "Shift write-back without a preceding history read.")

endmodule

`default_nettype wire

### src/arwe_dp.sv
// ----------------------------------------------------------------------------
// Angular rate window estimator datapath
// History memories, blade shift, window difference, divider and vote counter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "angular_rate_window_estimator_unit_macros.svh"

module arwe_dp
  import arwe_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  arwe_cmd_t                 cmd_i,
  output arwe_sts_t                 sts_o,
  input  logic                      window_steps_we_i,
  input  logic [WS_W-1:0]           window_steps_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  input  logic [TIME_W-1:0]         timestamp_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      rate_valid_o,
  output logic signed [RATE_W-1:0]  angular_rate_o,
  output logic                      direction_o
);

  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW = (AW > WS_W) ? AW : WS_W;

  // Configuration and control state.
  logic [WS_W-1:0] ws_q;
  logic [CW-1:0]   cnt_q, cnt_inc;
  logic [AW-1:0]   wp_q, wp_inc;
  logic [AW-1:0]   p_q;
  logic [AW-1:0]   k_q;
  logic [AW-1:0]   steps_q, steps_eff;
  logic [SW-1:0]   steps_tmp;
  logic [IT_W-1:0] it_q;
  logic signed [VOTE_W-1:0] votes_q, votes_new;
  logic            dir_q;
  logic            out_valid_q;

  // Payload registers.
  logic signed [ANGLE_W-1:0] a0_q, as_q;
  logic [TIME_W-1:0]         t0_q, ts_q, dt_q;
  logic signed [17:0]        off_q;
  logic                      jnz_q;
  logic                      dneg_q, dzero_q;
  logic [ANGLE_W-1:0]        dmag_q;
  logic [NUM_W-1:0]          num_q, rem_q;
  logic [DEN_W-1:0]          den_q;
  logic [QUO_W-1:0]          quo_q;
  logic                      ovf_q;
  logic                      res_valid_q;
  logic signed [RATE_W-1:0]  res_rate_q;
  logic                      out_rv_q, out_dir_q;
  logic signed [RATE_W-1:0]  out_rate_q;

  // History memories.
  logic [AW:0]               sdiff, ssum;
  logic [AW-1:0]             slot;
  logic                      ang_we;
  logic [AW-1:0]             ang_waddr;
  logic [ANGLE_W-1:0]        ang_wdata, ang_rdata;
  logic [TIME_W-1:0]         time_rdata;

  // Combinational datapath values.
  logic signed [16:0]        d_raw, d_unw;
  logic [16:0]               d_abs;
  logic [3:0]                jcnt;
  logic signed [17:0]        off_abs;
  logic signed [ANGLE_W-1:0] ak;
  logic signed [17:0]        v_sum, v_w1, v_w2;
  logic signed [ANGLE_W-1:0] v_sat;
  logic signed [16:0]        bd_raw, bd_1, bd_2;
  logic [16:0]               bd_abs;
  logic                      div_ge;
  logic                      rnd;
  logic [RATE_W-1:0]         qr, rmag;
  logic                      vote_up;

  assign steps_tmp = (ws_q == '0) ? SW'(1) : SW'(ws_q);
  assign steps_eff = (steps_tmp > SW'(MAX_WINDOW - 1)) ? AW'(MAX_WINDOW - 1)
                                                       : steps_tmp[AW-1:0];
  assign cnt_inc   = (cnt_q == CW'(MAX_WINDOW)) ? cnt_q : cnt_q + 1'b1;
  assign wp_inc    = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;

  assign sdiff = {1'b0, p_q} - {1'b0, k_q};
  assign ssum  = sdiff + (AW+1)'(MAX_WINDOW);
  assign slot  = sdiff[AW] ? ssum[AW-1:0] : sdiff[AW-1:0];

  assign ak = $signed(ang_rdata);

  // Newest step, unwrapped by a full turn, rounded to whole blade jumps.
  always_comb begin
    d_raw = $signed({a0_q[15], a0_q}) - $signed({ak[15], ak});
    if (d_raw > STEP_UNWRAP_Q) begin
      d_unw = 17'(d_raw - TWO_PI_Q);
    end else if (d_raw < -STEP_UNWRAP_Q) begin
      d_unw = 17'(d_raw + TWO_PI_Q);
    end else begin
      d_unw = d_raw;
    end
    d_abs = d_unw[16] ? 17'(-d_unw) : d_unw;
    jcnt  = '0;
    for (int m = 1; m <= MAX_JUMPS; m++) begin
      if ((int'(d_abs) * 2 + BLADE_Q) >= (m * 2 * BLADE_Q)) begin
        jcnt = jcnt + 4'd1;
      end
    end
    off_abs = 18'(int'(jcnt) * BLADE_Q);
  end

  // Shifted older angle with one wrap and saturation.
  always_comb begin
    v_sum = $signed({{2{ak[15]}}, ak}) + off_q;
    v_w1  = (v_sum < -TWO_PI_Q) ? 18'(v_sum + TWO_PI_Q) : v_sum;
    v_w2  = (v_w1 > TWO_PI_Q) ? 18'(v_w1 - TWO_PI_Q) : v_w1;
    if (v_w2 > 32767) begin
      v_sat = 16'sh7FFF;
    end else if (v_w2 < -32768) begin
      v_sat = 16'sh8000;
    end else begin
      v_sat = v_w2[15:0];
    end
  end

  // Window difference with unwrap.
  always_comb begin
    bd_raw = $signed({a0_q[15], a0_q}) - $signed({as_q[15], as_q});
    bd_1   = (bd_raw > WIN_UNWRAP_Q) ? 17'(bd_raw - TWO_PI_Q) : bd_raw;
    bd_2   = (bd_1 < -WIN_UNWRAP_Q) ? 17'(bd_1 + TWO_PI_Q) : bd_1;
    bd_abs = bd_2[16] ? 17'(-bd_2) : bd_2;
  end

  assign div_ge = DEN_W'(rem_q) >= den_q;

  // Rounding, clamping and the direction vote.
  always_comb begin
    rnd = {rem_q, 1'b0} >= (NUM_W+1)'(dt_q);
    qr  = RATE_W'(quo_q) + RATE_W'(rnd);
    if (dzero_q) begin
      rmag = '0;
    end else if (ovf_q || (qr > RATE_W'(RATE_LIMIT_Q))) begin
      rmag = RATE_W'(RATE_CLAMP_Q);
    end else begin
      rmag = qr;
    end
    vote_up = !dneg_q && (rmag != '0);
    if (vote_up) begin
      votes_new = (votes_q != 16'sh7FFF) ? votes_q + 16'sd1 : votes_q;
    end else begin
      votes_new = (votes_q != 16'sh8000) ? votes_q - 16'sd1 : votes_q;
    end
  end

  assign ang_we    = cmd_i.accept || (cmd_i.shift_wr && jnz_q);
  assign ang_waddr = cmd_i.accept ? wp_q : slot;
  assign ang_wdata = cmd_i.accept ? angle_i : v_sat;

  arwe_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_angle_ram (
    .clk_i   (clk_i),
    .we_i    (ang_we),
    .waddr_i (ang_waddr),
    .wdata_i (ang_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (slot),
    .rdata_o (ang_rdata)
  );

  arwe_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_WINDOW)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wp_q),
    .wdata_i (timestamp_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (slot),
    .rdata_o (time_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= WS_W'(WS_RESET);
      cnt_q       <= '0;
      wp_q        <= '0;
      p_q         <= '0;
      k_q         <= '0;
      steps_q     <= '0;
      it_q        <= '0;
      votes_q     <= '0;
      dir_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (window_steps_we_i) begin
        ws_q <= window_steps_i;
      end
      if (cmd_i.accept) begin
        cnt_q   <= cnt_inc;
        wp_q    <= wp_inc;
        p_q     <= wp_q;
        k_q     <= AW'(1);
        steps_q <= steps_eff;
      end
      if (cmd_i.shift_wr) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.div_init) begin
        it_q <= IT_W'(QUO_W - 1);
      end else if (cmd_i.div_iter) begin
        it_q <= it_q - 1'b1;
      end
      if (cmd_i.finish) begin
        votes_q <= votes_new;
        dir_q   <= (votes_new > 16'sd0);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a0_q        <= angle_i;
      t0_q        <= timestamp_i;
      res_valid_q <= sts_o.full;
      res_rate_q  <= '0;
    end
    if (cmd_i.step_calc) begin
      off_q <= d_unw[16] ? -off_abs : off_abs;
      jnz_q <= (jcnt != '0);
    end
    if (cmd_i.shift_wr && (k_q == steps_q)) begin
      as_q <= jnz_q ? v_sat : ak;
      ts_q <= time_rdata;
    end
    if (cmd_i.diff_calc) begin
      dneg_q  <= bd_2[16];
      dzero_q <= (bd_2 == '0);
      dmag_q  <= bd_abs[ANGLE_W-1:0];
      dt_q    <= t0_q - ts_q;
    end
    if (cmd_i.mul) begin
      num_q <= NUM_W'(dmag_q) * NUM_W'(RATE_SCALE);
    end
    if (cmd_i.div_init) begin
      ovf_q <= DEN_W'(num_q) >= {dt_q, QUO_W'(0)};
      rem_q <= num_q;
      den_q <= DEN_W'(dt_q) << (QUO_W - 1);
      quo_q <= '0;
    end else if (cmd_i.div_iter) begin
      if (div_ge) begin
        rem_q <= rem_q - den_q[NUM_W-1:0];
      end
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
      den_q <= den_q >> 1;
    end
    if (cmd_i.finish) begin
      res_rate_q <= dneg_q ? -$signed(rmag) : $signed(rmag);
    end
    if (cmd_i.out_load) begin
      out_rv_q   <= res_valid_q;
      out_rate_q <= res_rate_q;
      out_dir_q  <= dir_q;
    end
  end

  assign sts_o.full     = cnt_inc > CW'(steps_eff);
  assign sts_o.k_last   = (k_q == steps_q);
  assign sts_o.div_last = (it_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign rate_valid_o   = out_rv_q;
  assign angular_rate_o = out_rate_q;
  assign direction_o    = out_dir_q;

  `ARWE_ASSERT_IMP(a_out_from_load, $rose(out_valid_q), $past(cmd_i.out_load),
                   "Result became valid without a load from the controller.")
  `ARWE_ASSERT_NXT(a_votes_hold, !cmd_i.finish, $stable(votes_q),
                   "Direction votes changed outside the final step.")
  `ARWE_ASSERT_IMP(a_k_range, cmd_i.shift_wr, (k_q != '0) && (k_q <= steps_q),
                   "Shift index left the window.")

endmodule

`default_nettype wire

### src/angular_rate_window_estimator_unit.sv
// ----------------------------------------------------------------------------
// Angular rate window estimator
// Finite-difference angular rate over a sliding window of angle samples.
// ----------------------------------------------------------------------------
// Each input request carries one Q3.12 angle and a microsecond timestamp on a
// valid/ready channel. Each request produces exactly one result request with
// rate_valid, a Q2.13 angular rate and the rotation direction.
// Until the window holds window_steps+1 samples the result skips the history
// shift and the divider and is returned with rate_valid low and the rate zero.
// With a full window the block reads and shifts window_steps history entries
// one at a time and then runs a 15-bit restoring divider. A new request is
// taken in the cycle after the previous result is loaded; the block takes no
// new request while one is in process. The divider loop and the single read
// port of each history memory set the request rate.
// The result sits in an output register; when the receiver stalls the block
// still accepts the next request and holds its result until the register
// frees. window_steps may be written only while the block is idle.
// Reset clears the sample count, the vote counter and sets direction to 1;
// the history memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module angular_rate_window_estimator_unit
  import arwe_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      window_steps_we_i,
  input  logic [WS_W-1:0]           window_steps_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ANGLE_W-1:0] angle_i,
  input  logic [TIME_W-1:0]         timestamp_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      rate_valid_o,
  output logic signed [RATE_W-1:0]  angular_rate_o,
  output logic                      direction_o
);

  arwe_cmd_t cmd;
  arwe_sts_t sts;

  arwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arwe_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .window_steps_we_i (window_steps_we_i),
    .window_steps_i    (window_steps_i),
    .angle_i           (angle_i),
    .timestamp_i       (timestamp_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .rate_valid_o      (rate_valid_o),
    .angular_rate_o    (angular_rate_o),
    .direction_o       (direction_o)
  );

endmodule

`default_nettype wire
